### sv/torque_sine_step_generator_assert.svh
// assertion macros shared by the torque setpoint generator modules
`ifndef TORQUE_SINE_STEP_GENERATOR_ASSERT_SVH
`define TORQUE_SINE_STEP_GENERATOR_ASSERT_SVH

// same-cycle implication
`define TSSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tssg_pkg.sv
// shared types, constants and sine table function for the torque setpoint generator
package tssg_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_STEP_MODE   = 3'd0,
      REG_AMPLITUDE   = 3'd1,
      REG_OFFSET      = 3'd2,
      REG_PHASE_STEP  = 3'd3,
      REG_STEP_PERIOD = 3'd4,
      REG_RAMP_STEP   = 3'd5
   } reg_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int AMP_W    = 15;
   localparam int TORQUE_W = 16;
   localparam int PERIOD_W = 20;
   localparam int TICK_W   = 21;
   localparam int RAMP_W   = 17;
   localparam int SINE_W   = 15;
   localparam int SUM_W    = 17;

   localparam logic [RAMP_W:0]     RAMP_ONE     = 18'd65536;
   localparam logic [14:0]         TORQUE_LIMIT = 15'd20000;

   // reset values of the configuration registers
   localparam logic [AMP_W-1:0]    AMP_RESET    = 15'd1000;
   localparam logic [31:0]         PSTEP_RESET  = 32'd429497;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd10000;
   localparam logic [RAMP_W-1:0]   RSTEP_RESET  = 17'd33;

   // serial multiplier operand widths and step counter
   localparam int MUL_A_W   = 16;
   localparam int MUL_B_W   = 17;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_rsp_type;

   // taylor coefficients of sin(pi/2 * z), q30 magnitudes
   localparam longint unsigned K1 = 64'd1686629713;
   localparam longint unsigned K3 = 64'd693598668;
   localparam longint unsigned K5 = 64'd85569306;
   localparam longint unsigned K7 = 64'd5026995;

   // quarter-wave sine entry in q15, evaluated at elaboration
   function automatic logic [SINE_W-1:0] quarter_sine_q15(input int unsigned p,
                                                          input int unsigned tbits);
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      z  = longint'(p) << (32 - tbits);
      z2 = (z * z) >> 30;
      t  = K5 - ((z2 * K7) >> 30);
      t  = K3 - ((z2 * t) >> 30);
      t  = K1 - ((z2 * t) >> 30);
      t  = (z * t) >> 30;
      t  = (t + 64'd16384) >> 15;
      if (t > 64'd32767) begin
         t = 64'd32767;
      end
      return t[SINE_W-1:0];
   endfunction

endpackage

### sv/tssg_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module tssg_serial_mul
   import tssg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

`include "torque_sine_step_generator_assert.svh"

   logic [MUL_A_W-1:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_A_W:0]     sum;

   // partial sum of the upper half and the selected multiplicand
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         hi_in    = '0;
         lo_in    = mul_req.mplier;
         mcand_in = mul_req.mcand;
         count_in = MUL_CNT_W'(MUL_B_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift the sum down into the multiplier register
         hi_in    = sum[MUL_A_W:1];
         lo_in    = {sum[0], lo_ff[MUL_B_W-1:1]};
         count_in = count_ff - MUL_CNT_W'(1);
         if (count_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = {hi_ff, lo_ff};

   `TSSG_ASSERT_NOW(a_start_idle, clock, reset, mul_req.start, !busy_ff,
                    "multiplier started while busy")
   `TSSG_ASSERT_NEXT(a_start_busy, clock, reset, mul_req.start,
                     busy_ff && (count_ff == MUL_CNT_W'(MUL_B_W)), "multiplier failed to load")
   `TSSG_ASSERT_NOW(a_done_after, clock, reset, done_ff, !busy_ff && (count_ff == '0),
                    "done raised with steps left")

endmodule

### sv/torque_sine_step_generator.sv
// sequence: a step mode request goes from idle straight to the done state; sine mode runs
// two passes of the shared multiplier at one bit a cycle (17 steps plus a load each) with the
// lookup, sum, scale and output steps
// requests: one at a time, a new one is taken only back in idle, after the result of the last
// is loaded into the output register. reset clears phase, ramp, tick counter, sign and held value
// and loads the csr defaults
module torque_sine_step_generator
   import tssg_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TORQUE_W-1:0] rsp_torque_mnm,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

`include "torque_sine_step_generator_assert.svh"

   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam int ADDR_W  = SINE_TABLE_BITS - 1;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_SIN_LOAD  = 8'b0000_0010,
      ST_SIN_MUL   = 8'b0000_0100,
      ST_SUM       = 8'b0000_1000,
      ST_RAMP_LOAD = 8'b0001_0000,
      ST_RAMP_MUL  = 8'b0010_0000,
      ST_SCALE     = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic                      step_mode_ff;
   logic signed [AMP_W-1:0]   amp_ff;
   logic signed [AMP_W-1:0]   off_ff;
   logic [31:0]               pstep_ff;
   logic [PERIOD_W-1:0]       period_ff;
   logic [RAMP_W-1:0]         rstep_ff;

   // tick state
   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [RAMP_W-1:0]         ramp_ff, ramp_in;
   logic [TICK_W-1:0]         tick_ff, tick_in;
   logic                      sign_neg_ff, sign_neg_in;
   logic signed [TORQUE_W-1:0] held_ff, held_in;

   // datapath registers
   logic [SINE_W-1:0]         sine_mag_ff, sine_mag_in;
   logic                      sine_neg_ff, sine_neg_in;
   logic [RAMP_W-1:0]         ramp_use_ff, ramp_use_in;
   logic signed [SUM_W-1:0]   w_ff, w_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TORQUE_W-1:0] rsp_torque_ff, rsp_torque_in;

   logic                      accept;
   logic                      out_load;
   logic [PHASE_BITS-1:0]     phase_use;
   logic [RAMP_W-1:0]         ramp_now;
   logic [RAMP_W:0]           ramp_sum;
   logic [SINE_TABLE_BITS-1:0] sine_idx;
   logic [ADDR_W-1:0]         rom_addr;
   logic [SINE_W-1:0]         sine_rom [QUARTER+1];
   logic signed [SUM_W-1:0]   amp_ext;
   logic signed [SUM_W-1:0]   off_ext;
   logic signed [SUM_W-1:0]   step_sum;
   logic signed [TORQUE_W-1:0] step_sat;
   logic [MUL_A_W-1:0]        amp_mag;
   logic [MUL_A_W-1:0]        w_mag;
   logic [SUM_W-1:0]          w_neg_val;
   logic [30:0]               m1_sum;
   logic [MUL_A_W-1:0]        m1;
   logic [32:0]               m2_sum;
   logic [16:0]               m2;
   logic [14:0]               m2_sat;
   logic signed [TORQUE_W-1:0] sine_torque;
   mul_req_type               mul_req;
   mul_rsp_type               mul_rsp;

   // quarter-wave sine table
   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
      assign sine_rom[gi] = quarter_sine_q15(gi, SINE_TABLE_BITS);
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // restart clears phase and ramp before the tick
   assign phase_use = req_restart ? '0 : phase_ff;
   assign ramp_now  = req_restart ? '0 : ramp_ff;
   assign ramp_sum  = {1'b0, ramp_now} + {1'b0, rstep_ff};

   // quarter-wave folding of the table index
   assign sine_idx = phase_use[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign rom_addr = sine_idx[SINE_TABLE_BITS-2]
                   ? ADDR_W'(QUARTER) - {1'b0, sine_idx[SINE_TABLE_BITS-3:0]}
                   : {1'b0, sine_idx[SINE_TABLE_BITS-3:0]};

   // step value: offset plus or minus amplitude, saturated
   assign amp_ext  = SUM_W'(amp_ff);
   assign off_ext  = SUM_W'(off_ff);
   assign step_sum = sign_neg_ff ? off_ext - amp_ext : off_ext + amp_ext;
   always_comb begin
      if (step_sum > $signed({2'b00, TORQUE_LIMIT})) begin
         step_sat = $signed({1'b0, TORQUE_LIMIT});
      end else if (step_sum < -$signed({2'b00, TORQUE_LIMIT})) begin
         step_sat = -$signed({1'b0, TORQUE_LIMIT});
      end else begin
         step_sat = step_sum[TORQUE_W-1:0];
      end
   end

   // magnitudes for the multiplier
   assign amp_mag   = amp_ff[AMP_W-1] ? MUL_A_W'(-amp_ext) : MUL_A_W'(amp_ext);
   assign w_neg_val = -w_ff;
   assign w_mag     = w_ff[SUM_W-1] ? w_neg_val[MUL_A_W-1:0] : w_ff[MUL_A_W-1:0];

   // amplitude times sine, rounded half away from zero, plus offset
   assign m1_sum = {1'b0, mul_rsp.product[29:0]} + 31'd16384;
   assign m1     = m1_sum[30:15];

   // ramp scaling, rounded, saturated on the magnitude
   assign m2_sum = {1'b0, mul_rsp.product[31:0]} + 33'd32768;
   assign m2     = m2_sum[32:16];
   assign m2_sat = (m2 > {2'b00, TORQUE_LIMIT}) ? TORQUE_LIMIT : m2[14:0];
   assign sine_torque = w_ff[SUM_W-1] ? -$signed({1'b0, m2_sat}) : $signed({1'b0, m2_sat});

   // multiplier operands
   always_comb begin
      mul_req.start  = (state_ff == ST_SIN_LOAD) || (state_ff == ST_RAMP_LOAD);
      mul_req.mcand  = (state_ff == ST_SIN_LOAD) ? amp_mag : w_mag;
      mul_req.mplier = (state_ff == ST_SIN_LOAD) ? MUL_B_W'(sine_mag_ff) : ramp_use_ff;
   end

   tssg_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // sequencer and tick state update
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      ramp_in       = ramp_ff;
      tick_in       = tick_ff;
      sign_neg_in   = sign_neg_ff;
      held_in       = held_ff;
      sine_mag_in   = sine_mag_ff;
      sine_neg_in   = sine_neg_ff;
      ramp_use_in   = ramp_use_ff;
      w_in          = w_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_torque_in = rsp_torque_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in    = phase_use + PHASE_BITS'(pstep_ff);
               ramp_in     = (ramp_sum > RAMP_ONE) ? RAMP_ONE[RAMP_W-1:0] : ramp_sum[RAMP_W-1:0];
               sine_mag_in = sine_rom[rom_addr];
               sine_neg_in = sine_idx[SINE_TABLE_BITS-1];
               ramp_use_in = ramp_now;
               if (step_mode_ff) begin
                  if (tick_ff > TICK_W'(period_ff)) begin
                     held_in     = step_sat;
                     sign_neg_in = !sign_neg_ff;
                     tick_in     = TICK_W'(1);
                  end else if (tick_ff != '1) begin
                     tick_in = tick_ff + TICK_W'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SIN_LOAD;
               end
            end
         end
         ST_SIN_LOAD: begin
            state_in = ST_SIN_MUL;
         end
         ST_SIN_MUL: begin
            if (mul_rsp.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sine_neg_ff ^ amp_ff[AMP_W-1]) begin
               w_in = off_ext - $signed({1'b0, m1});
            end else begin
               w_in = off_ext + $signed({1'b0, m1});
            end
            state_in = ST_RAMP_LOAD;
         end
         ST_RAMP_LOAD: begin
            state_in = ST_RAMP_MUL;
         end
         ST_RAMP_MUL: begin
            if (mul_rsp.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            held_in  = sine_torque;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_torque_in = held_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         ramp_ff      <= '0;
         tick_ff      <= '0;
         sign_neg_ff  <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ramp_ff      <= ramp_in;
         tick_ff      <= tick_in;
         sign_neg_ff  <= sign_neg_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sine_mag_ff   <= sine_mag_in;
      sine_neg_ff   <= sine_neg_in;
      ramp_use_ff   <= ramp_use_in;
      w_ff          <= w_in;
      rsp_torque_ff <= rsp_torque_in;
   end

   // csr write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         step_mode_ff <= 1'b0;
         amp_ff       <= AMP_RESET;
         off_ff       <= '0;
         pstep_ff     <= PSTEP_RESET;
         period_ff    <= PERIOD_RESET;
         rstep_ff     <= RSTEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_STEP_MODE:   step_mode_ff <= csr_data[0];
            REG_AMPLITUDE:   amp_ff       <= csr_data[AMP_W-1:0];
            REG_OFFSET:      off_ff       <= csr_data[AMP_W-1:0];
            REG_PHASE_STEP:  pstep_ff     <= csr_data;
            REG_STEP_PERIOD: period_ff    <= csr_data[PERIOD_W-1:0];
            REG_RAMP_STEP:   rstep_ff     <= csr_data[RAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_torque_mnm = rsp_torque_ff;

   `TSSG_ASSERT_NOW(a_done_in_mul, clock, reset, mul_rsp.done,
                    (state_ff == ST_SIN_MUL) || (state_ff == ST_RAMP_MUL),
                    "multiplier finished outside a multiply step")
   `TSSG_ASSERT_NEXT(a_step_fast, clock, reset, accept && step_mode_ff, state_ff == ST_DONE,
                     "step request did not finish at once")
   `TSSG_ASSERT_NOW(a_held_range, clock, reset, 1'b1,
                    (held_ff <= 16'sd20000) && (held_ff >= -16'sd20000),
                    "held torque out of range")
   `TSSG_ASSERT_NOW(a_ramp_cap, clock, reset, 1'b1, {1'b0, ramp_ff} <= RAMP_ONE,
                    "ramp level above one")

endmodule

### sim/tb_torque_sine_step_generator.sv
// self-checking testbench for the torque setpoint generator: directed and random ticks
module tb_torque_sine_step_generator;
   import tssg_pkg::*;

   localparam int PHASE_W    = 32;
   localparam int TABLE_BITS = 10;

   // spare csr indexes, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int FULL_RAMP      = 65536;
   localparam int SETPOINT_LIMIT = 20000;
   localparam logic [TICK_W-1:0] TICK_CEILING = '1;
   localparam longint unsigned QUARTER_SIZE = 64'd1 << (TABLE_BITS - 2);

   // taylor terms of sin(pi/2 * z) in q30
   localparam longint unsigned TAYLOR_K1 = 64'd1686629713;
   localparam longint unsigned TAYLOR_K3 = 64'd693598668;
   localparam longint unsigned TAYLOR_K5 = 64'd85569306;
   localparam longint unsigned TAYLOR_K7 = 64'd5026995;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [TORQUE_W-1:0] rsp_torque_mnm;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the csrs
   logic cfg_step_mode;
   logic signed [AMP_W-1:0] cfg_amplitude;
   logic signed [AMP_W-1:0] cfg_offset;
   logic [PHASE_W-1:0] cfg_phase_step;
   logic [PERIOD_W-1:0] cfg_step_period;
   logic [RAMP_W-1:0] cfg_ramp_step;

   // predictor copy of the tick state
   logic [PHASE_W-1:0] phase_acc;
   logic [RAMP_W-1:0] ramp_level;
   logic [TICK_W-1:0] tick_count;
   logic toggle_negative;
   logic signed [TORQUE_W-1:0] held_setpoint;

   logic signed [TORQUE_W-1:0] pending_torque[$];
   logic signed [TORQUE_W-1:0] torque_due;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   torque_sine_step_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_torque_mnm (rsp_torque_mnm),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // sine of pi/2 * p / quarter size in q15
   function automatic longint unsigned quarter_wave(longint unsigned p);
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      z  = p << (30 - (TABLE_BITS - 2));
      z2 = (z * z) >> 30;
      t  = TAYLOR_K5 - ((z2 * TAYLOR_K7) >> 30);
      t  = TAYLOR_K3 - ((z2 * t) >> 30);
      t  = TAYLOR_K1 - ((z2 * t) >> 30);
      t  = (z * t) >> 30;
      t  = (t + 64'd16384) >> 15;
      return (t > 64'd32767) ? 64'd32767 : t;
   endfunction

   // full-wave table value by quadrant folding
   function automatic int table_sine(logic [PHASE_W-1:0] phase);
      logic [TABLE_BITS-1:0] idx;
      longint unsigned p;
      int s;
      idx = phase[PHASE_W-1 -: TABLE_BITS];
      p = 64'(idx[TABLE_BITS-3:0]);
      if (idx[TABLE_BITS-2]) begin
         s = int'(quarter_wave(QUARTER_SIZE - p));
      end else begin
         s = int'(quarter_wave(p));
      end
      return idx[TABLE_BITS-1] ? -s : s;
   endfunction

   // shift right, nearest, ties away from zero
   function automatic longint round_half_away(longint v, int s);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [TORQUE_W-1:0] clamp_torque(longint v);
      if (v > SETPOINT_LIMIT) return TORQUE_W'(SETPOINT_LIMIT);
      if (v < -SETPOINT_LIMIT) return TORQUE_W'(-SETPOINT_LIMIT);
      return v[TORQUE_W-1:0];
   endfunction

   // one servo tick of the predictor, queues the setpoint it yields
   function automatic void predict_tick(logic restart);
      longint wave;
      longint swing;
      int ramp_sum;
      if (restart) begin
         phase_acc  = '0;
         ramp_level = '0;
      end
      if (cfg_step_mode) begin
         if (tick_count > cfg_step_period) begin
            swing = toggle_negative ? -longint'(cfg_amplitude) : longint'(cfg_amplitude);
            held_setpoint = clamp_torque(longint'(cfg_offset) + swing);
            toggle_negative = !toggle_negative;
            tick_count = '0;
         end
         if (tick_count != TICK_CEILING) begin
            tick_count = tick_count + TICK_W'(1);
         end
      end else begin
         wave = round_half_away(longint'(cfg_amplitude) * table_sine(phase_acc), 15);
         wave = wave + longint'(cfg_offset);
         held_setpoint = clamp_torque(round_half_away(wave * longint'(ramp_level), 16));
      end
      pending_torque.push_back(held_setpoint);
      phase_acc = phase_acc + cfg_phase_step;
      ramp_sum = int'(ramp_level) + int'(cfg_ramp_step);
      ramp_level = RAMP_W'((ramp_sum > FULL_RAMP) ? FULL_RAMP : ramp_sum);
   endfunction

   function automatic void reset_predictor();
      cfg_step_mode   = 1'b0;
      cfg_amplitude   = AMP_RESET;
      cfg_offset      = '0;
      cfg_phase_step  = PSTEP_RESET;
      cfg_step_period = PERIOD_RESET;
      cfg_ramp_step   = RSTEP_RESET;
      phase_acc       = '0;
      ramp_level      = '0;
      tick_count      = '0;
      toggle_negative = 1'b0;
      held_setpoint   = '0;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_STEP_MODE:   cfg_step_mode   = data[0];
         REG_AMPLITUDE:   cfg_amplitude   = data[AMP_W-1:0];
         REG_OFFSET:      cfg_offset      = data[AMP_W-1:0];
         REG_PHASE_STEP:  cfg_phase_step  = data[PHASE_W-1:0];
         REG_STEP_PERIOD: cfg_step_period = data[PERIOD_W-1:0];
         REG_RAMP_STEP:   cfg_ramp_step   = data[RAMP_W-1:0];
         default: ;
      endcase
   endfunction

   // 15-bit value with random upper bits
   function automatic logic [CSR_DATA_W-1:0] pad15(logic [AMP_W-1:0] v);
      logic [CSR_DATA_W-1:0] d;
      d = $urandom();
      d[AMP_W-1:0] = v;
      return d;
   endfunction

   task automatic flag_mismatch(string what, logic signed [TORQUE_W-1:0] want,
                                logic signed [TORQUE_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s): expected torque %0d, got %0d", what, want, got);
      end
   endtask

   // csr write, one cycle of enable
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      apply_csr(index, data);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_csrs(logic mode, logic [AMP_W-1:0] amplitude,
                                 logic [AMP_W-1:0] offset, logic [PHASE_W-1:0] phase_step,
                                 logic [PERIOD_W-1:0] period, logic [RAMP_W-1:0] ramp_step);
      write_csr(REG_STEP_MODE, {31'($urandom()), mode});
      write_csr(REG_AMPLITUDE, pad15(amplitude));
      write_csr(REG_OFFSET, pad15(offset));
      write_csr(REG_PHASE_STEP, phase_step);
      write_csr(REG_STEP_PERIOD, {12'($urandom()), period});
      write_csr(REG_RAMP_STEP, {15'($urandom()), ramp_step});
   endtask

   // one request, valid held until taken
   task automatic send_tick(logic restart);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(1));
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tick(restart);
   endtask

   // drop valid and let every result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_torque.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_torque.size() == 0) begin
               flag_mismatch("no request waiting", '0, rsp_torque_mnm);
            end else begin
               torque_due = pending_torque.pop_front();
               if (rsp_torque_mnm !== torque_due) begin
                  flag_mismatch("torque_mnm", torque_due, rsp_torque_mnm);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // reset values, restart from reset state
   task automatic test_power_on_defaults();
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // full-scale sine at quarter-turn steps, ramp jumps to one
   task automatic test_sine_extremes();
      wait_idle();
      write_all_csrs(1'b0, 15'sd10000, 15'sd10000, 32'h4000_0000, 20'd5, 17'd65536);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      wait_idle();
      // oversized ramp step still caps at one, phase wraps backwards
      write_all_csrs(1'b0, -15'sd10000, -15'sd10000, 32'hFFFF_FFFF, 20'd5, 17'h1FFFF);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // out-of-range amplitude and offset saturate the sine output
   task automatic test_sine_saturation();
      wait_idle();
      write_all_csrs(1'b0, 15'sd16383, 15'sd16383, 32'h4000_0000, 20'd5, 17'd65536);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_idle();
      write_csr(REG_AMPLITUDE, pad15(15'h4000));
      write_csr(REG_OFFSET, pad15(15'h4000));
      send_tick(1'b0);
   endtask

   // step toggling, offset write keeps held value, restart keeps counter
   task automatic test_step_toggle();
      wait_idle();
      write_all_csrs(1'b1, 15'sd7000, -15'sd3000, 32'h0123_4567, 20'd0, 17'd1000);
      repeat (3) send_tick(1'b0);
      wait_idle();
      write_csr(REG_STEP_PERIOD, 32'd3);
      write_csr(REG_OFFSET, pad15(15'sd2500));
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      wait_idle();
      write_csr(REG_AMPLITUDE, pad15(15'h4000));
      write_csr(REG_OFFSET, pad15(15'h4000));
      write_csr(REG_STEP_PERIOD, 32'd0);
      repeat (2) send_tick(1'b0);
      wait_idle();
      write_csr(REG_STEP_PERIOD, 32'hFFFF_FFFF);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // writes to the spare indexes change nothing
   task automatic test_spare_registers();
      wait_idle();
      write_csr(CSR_SPARE_LO, $urandom());
      write_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      write_csr(REG_STEP_MODE, 32'd0);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   function automatic logic [AMP_W-1:0] pick_torque_term();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return 15'($signed($urandom_range(20000)) - 10000);
      if (roll < 85) return $urandom_range(1) ? 15'sd10000 : -15'sd10000;
      return 15'($urandom());
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return PERIOD_W'($urandom_range(12));
      if (roll < 90) return PERIOD_W'($urandom_range(200));
      return 20'($urandom());
   endfunction

   function automatic logic [RAMP_W-1:0] pick_ramp_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return RAMP_W'($urandom_range(4000));
      if (roll < 70) return 17'd65536;
      if (roll < 80) return 17'd0;
      return 17'($urandom());
   endfunction

   // random settings and ticks under each idling pattern
   task automatic test_random_traffic();
      int sender_pct[4] = '{0, 73, 0, 8};
      int stall_pct[4]  = '{0, 0, 73, 8};
      int batch;
      for (int phase = 0; phase < 4; phase++) begin
         for (int segment = 0; segment < 4; segment++) begin
            wait_idle();
            send_idle_pct = sender_pct[phase];
            rsp_stall_pct = stall_pct[phase];
            write_all_csrs(1'($urandom_range(1)), pick_torque_term(), pick_torque_term(),
                           $urandom_range(1) ? $urandom() : $urandom_range(32'h0400_0000),
                           pick_period(), pick_ramp_step());
            if ($urandom_range(99) < 30) begin
               write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
            end
            batch = $urandom_range(100, 120);
            repeat (batch) send_tick($urandom_range(99) < 8);
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_defaults();
      test_sine_extremes();
      test_sine_saturation();
      test_step_toggle();
      test_spare_registers();
      test_random_traffic();
      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_torque.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
